// ----- design/ddsc_pkg.sv -----
package ddsc_pkg;

  localparam int FW        = 31;
  localparam int EXIT_W    = 32;
  localparam int MU_W      = 16;
  localparam int PROD_W    = 2 * FW;
  localparam int SUM_W     = 64;
  localparam int DVD_W     = 63;
  localparam int DEN_W     = 47;
  localparam int REM_W     = DEN_W + 1;
  localparam int QW        = 33;
  localparam int CNT_W     = $clog2(QW);
  localparam int EW        = 36;
  localparam int IN_DATA_W  = 192;
  localparam int OUT_DATA_W = 64;
  localparam int CFG_IDX_W  = 3;

  localparam logic [FW-1:0] MAX31 = {FW{1'b1}};

  localparam logic [MU_W-1:0] ABS_MU_RST   = 16'd32768;
  localparam logic            FORWARD_RST  = 1'b1;
  localparam logic [FW-1:0]   INFLOW_RST   = '0;
  localparam logic [FW-1:0]   INV_KEFF_RST = 31'd65536;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ABS_MU       = 3'd0,
    REG_FORWARD      = 3'd1,
    REG_LEFT_INFLOW  = 3'd2,
    REG_RIGHT_INFLOW = 3'd3,
    REG_INV_KEFF     = 3'd4
  } reg_idx_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_CAPTURE,
    OP_SP,
    OP_FK,
    OP_SRC,
    OP_SDX,
    OP_STDX,
    OP_SUM,
    OP_LOAD,
    OP_DIV,
    OP_FIN
  } op_t;

  typedef struct packed {
    op_t op;
  } cmd_t;

  typedef struct packed {
    logic div_last;
  } status_t;

  typedef struct packed {
    logic [MU_W-1:0] abs_mu;
    logic            forward;
    logic [FW-1:0]   left_inflow;
    logic [FW-1:0]   right_inflow;
    logic [FW-1:0]   inv_keff;
  } cfg_t;

endpackage

// ----- design/ddsc_ctrl.sv -----
module ddsc_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            s_tvalid,
  output logic            s_tready,
  output logic            m_tvalid,
  input  logic            m_tready,
  input  ddsc_pkg::status_t sts,
  output ddsc_pkg::cmd_t  cmd
);

  typedef enum logic [3:0] {
    S_IDLE, S_SP, S_FK, S_SRC, S_SDX, S_STDX, S_SUM, S_LOAD, S_DIV, S_FIN
  } state_t;

  state_t state;
  logic   fin_go;

  assign s_tready = (state == S_IDLE);
  assign fin_go   = !m_tvalid || m_tready;

  always_comb begin
    unique case (state)
      S_IDLE:  cmd.op = s_tvalid ? ddsc_pkg::OP_CAPTURE : ddsc_pkg::OP_NONE;
      S_SP:    cmd.op = ddsc_pkg::OP_SP;
      S_FK:    cmd.op = ddsc_pkg::OP_FK;
      S_SRC:   cmd.op = ddsc_pkg::OP_SRC;
      S_SDX:   cmd.op = ddsc_pkg::OP_SDX;
      S_STDX:  cmd.op = ddsc_pkg::OP_STDX;
      S_SUM:   cmd.op = ddsc_pkg::OP_SUM;
      S_LOAD:  cmd.op = ddsc_pkg::OP_LOAD;
      S_DIV:   cmd.op = ddsc_pkg::OP_DIV;
      S_FIN:   cmd.op = fin_go ? ddsc_pkg::OP_FIN : ddsc_pkg::OP_NONE;
      default: cmd.op = ddsc_pkg::OP_NONE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      if (state == S_FIN && fin_go) begin
        m_tvalid <= 1'b1;
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (s_tvalid) state <= S_SP;
        end
        S_SP:   state <= S_FK;
        S_FK:   state <= S_SRC;
        S_SRC:  state <= S_SDX;
        S_SDX:  state <= S_STDX;
        S_STDX: state <= S_SUM;
        S_SUM:  state <= S_LOAD;
        S_LOAD: state <= S_DIV;
        S_DIV: begin
          if (sts.div_last) state <= S_FIN;
        end
        S_FIN: begin
          if (fin_go) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ----- design/ddsc_dp.sv -----
module ddsc_dp (
  input  logic                               clk,
  input  logic                               rst,
  input  ddsc_pkg::cmd_t                     cmd,
  output ddsc_pkg::status_t                  sts,
  input  ddsc_pkg::cfg_t                     cfg,
  input  logic [ddsc_pkg::IN_DATA_W-1:0]     s_tdata,
  input  logic                               s_tuser,
  output logic [ddsc_pkg::OUT_DATA_W-1:0]    m_tdata,
  output logic                               m_tuser
);

  localparam int FW = ddsc_pkg::FW;

  logic [FW-1:0] dx, st, ss, q, phi, fis;
  logic signed [ddsc_pkg::EXIT_W-1:0] inflow;

  logic [ddsc_pkg::PROD_W-1:0] t1, t2, sdx, stdx;
  logic [FW-1:0]               src;
  logic signed [49:0]          m2in;
  logic signed [ddsc_pkg::SUM_W-1:0] num;
  logic [ddsc_pkg::DEN_W-1:0]  den;

  logic [ddsc_pkg::REM_W-1:0]  rem;
  logic [ddsc_pkg::QW-1:0]     dvd;
  logic [ddsc_pkg::DEN_W-1:0]  dsr;
  logic [ddsc_pkg::CNT_W-1:0]  cnt;
  logic                        ovf;
  logic                        fix;

  logic [FW-1:0]               cell_flux;
  logic signed [ddsc_pkg::EXIT_W-1:0] exit_flux;
  logic                        fixup_done;

  localparam int MU_W_L = ddsc_pkg::MU_W;
  logic [MU_W_L-1:0] mu;
  logic [MU_W_L:0]   mu2;

  logic [FW-1:0]               mul_a, mul_b;
  logic [ddsc_pkg::PROD_W-1:0] mul_p;
  logic [46:0]                 src_sum;

  logic [ddsc_pkg::DVD_W-1:0]  dividend;
  logic [ddsc_pkg::DEN_W-1:0]  divisor;
  logic [ddsc_pkg::REM_W-1:0]  trial;
  logic                        ge;

  logic [ddsc_pkg::QW-1:0]          qs;
  logic signed [ddsc_pkg::EW-1:0]   e_raw;
  logic signed [ddsc_pkg::EW-1:0]   inflow_x;
  logic [FW-1:0]                    cell_next;
  logic signed [ddsc_pkg::EXIT_W-1:0] exit_next;

  assign mu  = (cfg.abs_mu == '0) ? MU_W_L'(1) : cfg.abs_mu;
  assign mu2 = {mu, 1'b0};

  always_comb begin
    case (cmd.op)
      ddsc_pkg::OP_SP:   begin mul_a = ss;  mul_b = phi;          end
      ddsc_pkg::OP_FK:   begin mul_a = fis; mul_b = cfg.inv_keff; end
      ddsc_pkg::OP_SDX:  begin mul_a = src; mul_b = dx;           end
      default:           begin mul_a = st;  mul_b = dx;           end
    endcase
  end
  assign mul_p = mul_a * mul_b;

  assign src_sum = 47'(t1[ddsc_pkg::PROD_W-1:17]) + 47'(q[FW-1:1])
                 + 47'(t2[ddsc_pkg::PROD_W-1:17]);

  assign dividend = num[ddsc_pkg::SUM_W-1] ? {1'b0, sdx}
                                           : num[ddsc_pkg::DVD_W-1:0];
  assign divisor  = num[ddsc_pkg::SUM_W-1] ? ddsc_pkg::DEN_W'(mu) : den;

  assign trial = {rem[ddsc_pkg::REM_W-2:0], dvd[ddsc_pkg::QW-1]};
  assign ge    = trial >= {1'b0, dsr};

  assign sts.div_last = (cnt == ddsc_pkg::CNT_W'(ddsc_pkg::QW - 1));

  // quotient held saturated to 33 bits; beyond that both outputs saturate
  assign qs       = ovf ? '1 : dvd;
  assign inflow_x = ddsc_pkg::EW'(inflow);

  always_comb begin
    if (fix) begin
      e_raw     = $signed({3'b000, qs}) + inflow_x;
      cell_next = '0;
    end else begin
      e_raw     = $signed({2'b00, qs, 1'b0}) - inflow_x;
      cell_next = (qs[ddsc_pkg::QW-1:FW] != '0) ? ddsc_pkg::MAX31 : qs[FW-1:0];
    end
    if (fix && e_raw < 0) begin
      exit_next = '0;
    end else if (e_raw > $signed(ddsc_pkg::EW'(32'h7FFF_FFFF))) begin
      exit_next = 32'sh7FFF_FFFF;
    end else if (e_raw < -$signed(ddsc_pkg::EW'(32'h8000_0000))) begin
      exit_next = 32'sh8000_0000;
    end else begin
      exit_next = e_raw[ddsc_pkg::EXIT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      inflow <= '0;
    end else begin
      case (cmd.op)
        ddsc_pkg::OP_CAPTURE: begin
          dx  <= s_tdata[0*FW +: FW];
          st  <= s_tdata[1*FW +: FW];
          ss  <= s_tdata[2*FW +: FW];
          q   <= s_tdata[3*FW +: FW];
          phi <= s_tdata[4*FW +: FW];
          fis <= s_tdata[5*FW +: FW];
          if (s_tuser) begin
            inflow <= $signed({1'b0, cfg.forward ? cfg.left_inflow : cfg.right_inflow});
          end
        end
        ddsc_pkg::OP_SP:   t1 <= mul_p;
        ddsc_pkg::OP_FK:   t2 <= mul_p;
        ddsc_pkg::OP_SRC: begin
          src  <= (src_sum[46:FW] != '0) ? ddsc_pkg::MAX31 : src_sum[FW-1:0];
          m2in <= $signed({1'b0, mu2}) * inflow;
        end
        ddsc_pkg::OP_SDX:  sdx  <= mul_p;
        ddsc_pkg::OP_STDX: stdx <= mul_p;
        ddsc_pkg::OP_SUM: begin
          num <= ddsc_pkg::SUM_W'(m2in) + $signed({2'b00, sdx});
          den <= ddsc_pkg::DEN_W'(mu2) + stdx[ddsc_pkg::PROD_W-1:16];
        end
        ddsc_pkg::OP_LOAD: begin
          fix <= num[ddsc_pkg::SUM_W-1];
          ovf <= ddsc_pkg::DEN_W'(dividend[ddsc_pkg::DVD_W-1:ddsc_pkg::QW]) >= divisor;
          rem <= ddsc_pkg::REM_W'(dividend[ddsc_pkg::DVD_W-1:ddsc_pkg::QW]);
          dvd <= dividend[ddsc_pkg::QW-1:0];
          dsr <= divisor;
          cnt <= '0;
        end
        ddsc_pkg::OP_DIV: begin
          rem <= ge ? trial - {1'b0, dsr} : trial;
          dvd <= {dvd[ddsc_pkg::QW-2:0], ge};
          cnt <= cnt + 1'b1;
        end
        ddsc_pkg::OP_FIN: begin
          cell_flux  <= cell_next;
          exit_flux  <= exit_next;
          fixup_done <= fix;
          inflow     <= exit_next;
        end
        default: ;
      endcase
    end
  end

  assign m_tdata = {1'b0, exit_flux, cell_flux};
  assign m_tuser = fixup_done;

endmodule

// ----- design/diamond_difference_sweep_cell_unit.sv -----
// Cells are taken one at a time: each passes through the accept cycle, seven
// multiply/setup steps, the 33-step radix-2 divider for the balance quotient and the output step.
// The next cell is taken while a finished result waits in the output register.
// Reset (rst, synchronous): controller idle, output invalid, inflow zero,
// configuration registers back to their defaults.
module diamond_difference_sweep_cell_unit (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  // cell_width, total_xs, scatter_xs, ext_source, scalar_flux, fission_term, zero pad
  input  logic [ddsc_pkg::IN_DATA_W-1:0]      s_tdata,
  // first_cell
  input  logic                                s_tuser,
  output logic                                m_tvalid,
  input  logic                                m_tready,
  // cell_flux, exit_flux, zero pad
  output logic [ddsc_pkg::OUT_DATA_W-1:0]     m_tdata,
  // fixup_done
  output logic                                m_tuser,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [ddsc_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [ddsc_pkg::FW-1:0]             cfg_data
);

  ddsc_pkg::cfg_t    cfg;
  ddsc_pkg::cmd_t    cmd;
  ddsc_pkg::status_t sts;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.abs_mu       <= ddsc_pkg::ABS_MU_RST;
      cfg.forward      <= ddsc_pkg::FORWARD_RST;
      cfg.left_inflow  <= ddsc_pkg::INFLOW_RST;
      cfg.right_inflow <= ddsc_pkg::INFLOW_RST;
      cfg.inv_keff     <= ddsc_pkg::INV_KEFF_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        ddsc_pkg::REG_ABS_MU:       cfg.abs_mu       <= cfg_data[ddsc_pkg::MU_W-1:0];
        ddsc_pkg::REG_FORWARD:      cfg.forward      <= cfg_data[0];
        ddsc_pkg::REG_LEFT_INFLOW:  cfg.left_inflow  <= cfg_data;
        ddsc_pkg::REG_RIGHT_INFLOW: cfg.right_inflow <= cfg_data;
        ddsc_pkg::REG_INV_KEFF:     cfg.inv_keff     <= cfg_data;
        default: ;
      endcase
    end
  end

  ddsc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  ddsc_dp u_dp (
    .clk     (clk),
    .rst     (rst),
    .cmd     (cmd),
    .sts     (sts),
    .cfg     (cfg),
    .s_tdata (s_tdata),
    .s_tuser (s_tuser),
    .m_tdata (m_tdata),
    .m_tuser (m_tuser)
  );

endmodule

// ----- design/ddsc_checker.sv -----
module ddsc_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            s_tvalid,
  input logic                            s_tready,
  input logic                            m_tvalid,
  input logic                            m_tready,
  input logic [ddsc_pkg::OUT_DATA_W-1:0] m_tdata,
  input logic                            m_tuser
);

  // a held result keeps its payload
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("result changed while stalled");

  // one cell in flight: busy right after a transfer
  a_busy: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input taken while a cell is in work");

  // fixup forces zero cell flux
  a_fix_cell: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> m_tdata[30:0] == 31'd0)
    else $error("fixup with nonzero cell flux");

  // fixup exit flux clamped at zero
  a_fix_exit: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> !m_tdata[62])
    else $error("fixup with negative exit flux");

endmodule

bind diamond_difference_sweep_cell_unit ddsc_checker u_ddsc_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);
